### rtl/core/jtag_msq_pkg.sv
// shared types and constants of the jtag master shift sequencer
package jtag_msq_pkg;

    // op codes on the input port
    localparam logic [2:0] OP_TAP_RESET = 3'd0;
    localparam logic [2:0] OP_SHIFT_IR  = 3'd1;
    localparam logic [2:0] OP_SHIFT_DR  = 3'd2;
    localparam logic [2:0] OP_RUN_IDLE  = 3'd3;

    // status codes on the result port
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BUSY      = 2'd1;
    localparam logic [1:0] STAT_BAD_LEN   = 2'd2;
    localparam logic [1:0] STAT_IDLE_TICK = 2'd3;

    // shift length limits and tms-high cycles of a tap reset
    localparam logic [6:0] IR_LEN_MAX       = 7'd32;
    localparam logic [6:0] DR_LEN_MAX       = 7'd64;
    localparam logic [6:0] RESET_TMS_CYCLES = 7'd5;

    localparam int DATA_W = 64;
    localparam int CNT_W  = 7;
    localparam int IDLE_W = 32;

    typedef enum logic [2:0] {
        CLS_TAP_RESET,
        CLS_SHIFT_IR,
        CLS_SHIFT_DR,
        CLS_RUN_IDLE,
        CLS_BAD_LEN,
        CLS_TICK
    } item_cls_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RESET,
        PH_NAV,
        PH_SHIFT,
        PH_HOME
    } phase_t;

    typedef enum logic [3:0] {
        TAP_TLR,
        TAP_RTI,
        TAP_SEL_DR,
        TAP_CAP_DR,
        TAP_SH_DR,
        TAP_EX1_DR,
        TAP_PAU_DR,
        TAP_EX2_DR,
        TAP_UPD_DR,
        TAP_SEL_IR,
        TAP_CAP_IR,
        TAP_SH_IR,
        TAP_EX1_IR,
        TAP_PAU_IR,
        TAP_EX2_IR,
        TAP_UPD_IR
    } tap_state_t;

    // classified item between the front and the back
    typedef struct packed {
        item_cls_t          cls;
        logic [DATA_W-1:0]  data;
        logic [CNT_W-1:0]   count;
        logic [IDLE_W-1:0]  idle;
        logic               idle_zero;
        logic               tdo;
    } item_t;

    // one result transfer
    typedef struct packed {
        logic               tck;
        logic               tms;
        logic               tdi;
        logic               done;
        logic [DATA_W-1:0]  rd;
        tap_state_t         tap;
        logic [1:0]         status;
        logic               busy;
    } res_t;

endpackage

### rtl/core/jtag_master_shift_sequencer_unit.sv
// top level of the jtag master shift sequencer
// items are registered in the command queue, results in the result queue
// throughput: one item per cycle while the result queue has room, one result per item
// the command queue and the result queue let each side stall on its own
// reset: both queues empty, tap tracked as test-logic-reset, no command in progress
// reset is asynchronous and active low; no clearing pass is needed
module jtag_master_shift_sequencer_unit #(
    parameter int CMD_QUEUE_DEPTH = 4,
    parameter int RES_QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    // item side
    input  logic        push,
    output logic        full,
    input  logic [2:0]  op,
    input  logic [63:0] shift_data,
    input  logic [6:0]  bit_count,
    input  logic [31:0] idle_cycles,
    input  logic        tdo_in,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic        tck_cycle,
    output logic        tms_out,
    output logic        tdi_out,
    output logic        done_res,
    output logic [63:0] read_data,
    output logic [3:0]  tap_now,
    output logic [1:0]  status,
    output logic        busy_res
);
    import jtag_msq_pkg::*;

    item_t front_item;     // classified item from the front
    item_t head_item;      // oldest queued item seen by the back
    res_t  back_res;       // result built by the back
    res_t  out_res;        // oldest result waiting for a transfer
    logic  cq_empty;
    logic  cq_pop;
    logic  rq_full;
    logic  rq_push;

    // front: op decode and length check, no state
    jtag_msq_front u_front (
        .op          (op),
        .shift_data  (shift_data),
        .bit_count   (bit_count),
        .idle_cycles (idle_cycles),
        .tdo_in      (tdo_in),
        .item        (front_item)
    );

    // command queue between front and back; full gates new transfers
    jtag_msq_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_item),
        .full    (full),
        .pop     (cq_pop),
        .rd_data (head_item),
        .empty   (cq_empty)
    );

    // back: executes one queued item per cycle while the result queue has room
    jtag_msq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!cq_empty),
        .in_take   (cq_pop),
        .item      (head_item),
        .res_ready (!rq_full),
        .res_push  (rq_push),
        .res       (back_res)
    );

    // result queue doubles as output register and skid space
    jtag_msq_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (rq_push),
        .wr_data (back_res),
        .full    (rq_full),
        .pop     (pop),
        .rd_data (out_res),
        .empty   (empty)
    );

    // unpack the head result onto the ports
    assign tck_cycle = out_res.tck;
    assign tms_out   = out_res.tms;
    assign tdi_out   = out_res.tdi;
    assign done_res  = out_res.done;
    assign read_data = out_res.rd;
    assign tap_now   = 4'(out_res.tap);
    assign status    = out_res.status;
    assign busy_res  = out_res.busy;

endmodule

### rtl/core/jtag_msq_fifo.sv
// small first-in first-out queue used between the stages
module jtag_msq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/core/jtag_msq_front.sv
// front stage: decodes op and checks shift length
module jtag_msq_front (
    input  logic [2:0]                     op,
    input  logic [jtag_msq_pkg::DATA_W-1:0] shift_data,
    input  logic [jtag_msq_pkg::CNT_W-1:0]  bit_count,
    input  logic [jtag_msq_pkg::IDLE_W-1:0] idle_cycles,
    input  logic                           tdo_in,
    output jtag_msq_pkg::item_t            item
);
    import jtag_msq_pkg::*;

    logic ir_len_bad, dr_len_bad;

    assign ir_len_bad = (bit_count == '0) || (bit_count > IR_LEN_MAX);
    assign dr_len_bad = (bit_count == '0) || (bit_count > DR_LEN_MAX);

    always_comb
    begin
        item.data      = shift_data;
        item.count     = bit_count;
        item.idle      = idle_cycles;
        item.idle_zero = (idle_cycles == '0);
        item.tdo       = tdo_in;
        unique case (op)
            OP_TAP_RESET: item.cls = CLS_TAP_RESET;
            OP_SHIFT_IR:  item.cls = ir_len_bad ? CLS_BAD_LEN : CLS_SHIFT_IR;
            OP_SHIFT_DR:  item.cls = dr_len_bad ? CLS_BAD_LEN : CLS_SHIFT_DR;
            OP_RUN_IDLE:  item.cls = CLS_RUN_IDLE;
            default:      item.cls = CLS_TICK;
        endcase
    end

endmodule

### rtl/core/jtag_msq_back.sv
// back stage: tap tracking, path walking, shifting and capture
module jtag_msq_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_take,
    input  jtag_msq_pkg::item_t item,
    input  logic                res_ready,
    output logic                res_push,
    output jtag_msq_pkg::res_t  res
);
    import jtag_msq_pkg::*;

    function automatic tap_state_t tap_step(input tap_state_t s, input logic tms);
        tap_state_t n;
        unique case (s)
            TAP_TLR:    n = tms ? TAP_TLR    : TAP_RTI;
            TAP_RTI:    n = tms ? TAP_SEL_DR : TAP_RTI;
            TAP_SEL_DR: n = tms ? TAP_SEL_IR : TAP_CAP_DR;
            TAP_CAP_DR: n = tms ? TAP_EX1_DR : TAP_SH_DR;
            TAP_SH_DR:  n = tms ? TAP_EX1_DR : TAP_SH_DR;
            TAP_EX1_DR: n = tms ? TAP_UPD_DR : TAP_PAU_DR;
            TAP_PAU_DR: n = tms ? TAP_EX2_DR : TAP_PAU_DR;
            TAP_EX2_DR: n = tms ? TAP_UPD_DR : TAP_SH_DR;
            TAP_UPD_DR: n = tms ? TAP_SEL_DR : TAP_RTI;
            TAP_SEL_IR: n = tms ? TAP_TLR    : TAP_CAP_IR;
            TAP_CAP_IR: n = tms ? TAP_EX1_IR : TAP_SH_IR;
            TAP_SH_IR:  n = tms ? TAP_EX1_IR : TAP_SH_IR;
            TAP_EX1_IR: n = tms ? TAP_UPD_IR : TAP_PAU_IR;
            TAP_PAU_IR: n = tms ? TAP_EX2_IR : TAP_PAU_IR;
            TAP_EX2_IR: n = tms ? TAP_UPD_IR : TAP_SH_IR;
            TAP_UPD_IR: n = tms ? TAP_SEL_DR : TAP_RTI;
            default:    n = TAP_TLR;
        endcase
        return n;
    endfunction

    // tms that moves one step toward shift-ir or shift-dr
    function automatic logic tms_to_shift(input tap_state_t s, input logic ir);
        logic t;
        unique case (s)
            TAP_TLR:                t = 1'b0;
            TAP_SEL_DR, TAP_CAP_DR: t = ir;
            TAP_SEL_IR, TAP_CAP_IR: t = !ir;
            default:                t = 1'b1;
        endcase
        return t;
    endfunction

    function automatic logic tms_to_idle(input tap_state_t s);
        return !((s == TAP_TLR) || (s == TAP_RTI) || (s == TAP_UPD_DR) || (s == TAP_UPD_IR));
    endfunction

    phase_t             phase_reg, phase_next;
    tap_state_t         tap_reg, tap_next;
    logic               kind_ir_reg, kind_ir_next;
    logic [CNT_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [DATA_W-1:0]  out_shift_reg, out_shift_next;
    logic [DATA_W-1:0]  capture_reg, capture_next;
    logic [IDLE_W-1:0]  idle_left_reg, idle_left_next;

    logic               fire, is_cmd, cmd_start, tick_run;
    logic               tms_v, done_v, last_v;
    logic [CNT_W-1:0]   step_inc;
    tap_state_t         tap_after, target;
    logic [IDLE_W-1:0]  idle_after;

    assign fire      = in_valid && res_ready;
    assign in_take   = fire;
    assign res_push  = fire;
    assign is_cmd    = (item.cls != CLS_TICK);
    assign cmd_start = is_cmd && (phase_reg == PH_IDLE) && (item.cls != CLS_BAD_LEN);
    assign tick_run  = !is_cmd && (phase_reg != PH_IDLE);
    assign step_inc  = step_reg + 1'b1;
    assign last_v    = (step_inc >= total_reg);
    assign target    = kind_ir_reg ? TAP_SH_IR : TAP_SH_DR;

    // one tck cycle: tms choice, tap move, idle countdown and end of command
    always_comb
    begin
        tms_v      = 1'b0;
        done_v     = 1'b0;
        tap_after  = tap_reg;
        idle_after = idle_left_reg;
        if (tick_run)
        begin
            unique case (phase_reg)
                PH_RESET:
                begin
                    tms_v     = 1'b1;
                    tap_after = tap_step(tap_reg, 1'b1);
                    done_v    = (step_inc >= RESET_TMS_CYCLES);
                end
                PH_NAV:
                begin
                    tms_v     = tms_to_shift(tap_reg, kind_ir_reg);
                    tap_after = tap_step(tap_reg, tms_v);
                end
                PH_SHIFT:
                begin
                    tms_v     = last_v;
                    tap_after = tap_step(tap_reg, last_v);
                end
                PH_HOME:
                begin
                    if (tap_reg == TAP_RTI)
                    begin
                        if (idle_left_reg != '0)
                        begin
                            idle_after = idle_left_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        tms_v     = tms_to_idle(tap_reg);
                        tap_after = tap_step(tap_reg, tms_v);
                    end
                    done_v = (tap_after == TAP_RTI) && (idle_after == '0);
                end
                default:
                begin
                    tms_v = 1'b0;
                end
            endcase
        end
    end

    // result fields
    always_comb
    begin
        res.tck    = 1'b0;
        res.tms    = 1'b0;
        res.tdi    = 1'b0;
        res.done   = 1'b0;
        res.rd     = '0;
        res.tap    = tap_after;
        res.status = STAT_OK;
        res.busy   = 1'b0;
        if (is_cmd)
        begin
            if (phase_reg != PH_IDLE)
            begin
                res.status = STAT_BUSY;
                res.busy   = 1'b1;
            end
            else if (item.cls == CLS_BAD_LEN)
            begin
                res.status = STAT_BAD_LEN;
            end
            else if ((item.cls == CLS_RUN_IDLE) && (tap_reg == TAP_RTI) && item.idle_zero)
            begin
                res.done = 1'b1;
            end
            else
            begin
                res.busy = 1'b1;
            end
        end
        else if (phase_reg == PH_IDLE)
        begin
            res.status = STAT_IDLE_TICK;
        end
        else
        begin
            res.tck  = 1'b1;
            res.tms  = tms_v;
            res.tdi  = (phase_reg == PH_SHIFT) ? out_shift_reg[0] : 1'b0;
            res.done = done_v;
            res.rd   = done_v ? capture_reg : '0;
            res.busy = !done_v;
        end
    end

    // phase next state
    always_comb
    begin
        phase_next = phase_reg;
        if (fire && cmd_start)
        begin
            unique case (item.cls)
                CLS_TAP_RESET: phase_next = PH_RESET;
                CLS_RUN_IDLE:
                begin
                    phase_next = ((tap_reg == TAP_RTI) && item.idle_zero) ? PH_IDLE : PH_HOME;
                end
                default:       phase_next = PH_NAV;
            endcase
        end
        else if (fire && tick_run)
        begin
            unique case (phase_reg)
                PH_RESET: phase_next = done_v ? PH_IDLE : PH_RESET;
                PH_NAV:   phase_next = (tap_after == target) ? PH_SHIFT : PH_NAV;
                PH_SHIFT: phase_next = last_v ? PH_HOME : PH_SHIFT;
                PH_HOME:  phase_next = done_v ? PH_IDLE : PH_HOME;
                default:  phase_next = phase_reg;
            endcase
        end
    end

    // datapath next values
    always_comb
    begin
        tap_next       = tap_reg;
        kind_ir_next   = kind_ir_reg;
        step_next      = step_reg;
        total_next     = total_reg;
        out_shift_next = out_shift_reg;
        capture_next   = capture_reg;
        idle_left_next = idle_left_reg;
        if (fire && cmd_start)
        begin
            kind_ir_next   = (item.cls == CLS_SHIFT_IR);
            step_next      = '0;
            capture_next   = '0;
            out_shift_next = item.data;
            total_next     = ((item.cls == CLS_SHIFT_IR) || (item.cls == CLS_SHIFT_DR)) ?
                             item.count : '0;
            idle_left_next = (item.cls == CLS_RUN_IDLE) ? item.idle : '0;
        end
        else if (fire && tick_run)
        begin
            tap_next = tap_after;
            case (phase_reg)
                PH_RESET:
                begin
                    step_next = step_inc;
                end
                PH_NAV:
                begin
                    if (tap_after == target)
                    begin
                        step_next = '0;
                    end
                end
                PH_SHIFT:
                begin
                    if (item.tdo)
                    begin
                        capture_next[step_reg[5:0]] = 1'b1;
                    end
                    out_shift_next = out_shift_reg >> 1;
                    step_next      = step_inc;
                    if (last_v)
                    begin
                        idle_left_next = '0;
                    end
                end
                PH_HOME:
                begin
                    idle_left_next = idle_after;
                end
                default:
                begin
                    step_next = step_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tap_reg       <= TAP_TLR;
            kind_ir_reg   <= 1'b0;
            step_reg      <= '0;
            total_reg     <= '0;
            out_shift_reg <= '0;
            capture_reg   <= '0;
            idle_left_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            tap_reg       <= tap_next;
            kind_ir_reg   <= kind_ir_next;
            step_reg      <= step_next;
            total_reg     <= total_next;
            out_shift_reg <= out_shift_next;
            capture_reg   <= capture_next;
            idle_left_reg <= idle_left_next;
        end
    end

    a_busy_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> ($past(res.busy) == (phase_reg != PH_IDLE)))
        else $error("busy flag of last result disagrees with phase");

    a_not_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !res.busy) |=> (phase_reg == PH_IDLE))
        else $error("command ended but phase not idle");

    a_shift_in_shift_state: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SHIFT) |-> ((tap_reg == TAP_SH_DR) || (tap_reg == TAP_SH_IR)))
        else $error("shifting outside a shift state");

    a_shift_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SHIFT) |-> (step_reg < total_reg))
        else $error("shift counter ran past length");

    a_read_data_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (res.rd != '0)) |-> res.done)
        else $error("read data without done");

endmodule

### dv/jtag_master_shift_sequencer_unit_tb.sv
// self-checking testbench of the jtag master shift sequencer, queue handshake on both sides
`timescale 1ns / 1ps

module jtag_master_shift_sequencer_unit_tb;

    import jtag_msq_pkg::*;

    // clock tick op and the top of the unused op codes, which also act as ticks
    localparam logic [2:0] OP_CLOCK_TICK = 3'd4;
    localparam logic [2:0] OP_MAX        = 3'd7;

    // random stimulus stops once this many transfers are queued
    localparam int ITEM_TARGET = 420;
    // cycles with no transfer on either side before the run is given up
    localparam int STALL_LIMIT = 2000;
    // result latency of the block plus margin, waited out at the end
    localparam int DRAIN_CYCLES = 8;

    // one input transfer
    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] data;
        logic [6:0]  cnt;
        logic [31:0] idle;
        logic        tdo;
    } jtag_item_t;

    // sequencer state as tracked by the predictor
    typedef struct packed {
        tap_state_t  tap;
        phase_t      ph;
        logic [2:0]  kind;
        logic [6:0]  step;
        logic [6:0]  total;
        logic [63:0] out_bits;
        logic [63:0] cap_bits;
        logic [31:0] idle_left;
    } seq_model_t;

    typedef struct packed {
        seq_model_t st;
        res_t       res;
    } seq_step_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  op = OP_TAP_RESET;
    logic [63:0] shift_data = '0;
    logic [6:0]  bit_count = '0;
    logic [31:0] idle_cycles = '0;
    logic        tdo_in = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic        tck_cycle;
    logic        tms_out;
    logic        tdi_out;
    logic        done_res;
    logic [63:0] read_data;
    logic [3:0]  tap_now;
    logic [1:0]  status;
    logic        busy_res;

    jtag_item_t  pending_q[$];
    res_t        expected_q[$];
    seq_model_t  pred_st;
    seq_model_t  plan_st;
    jtag_item_t  drv_item;
    int          n_queued = 0;
    int          n_accepted = 0;
    int          n_errors = 0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          stall_cycles = 0;
    logic [31:0] rx_cycle = '0;

    jtag_master_shift_sequencer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .op          (op),
        .shift_data  (shift_data),
        .bit_count   (bit_count),
        .idle_cycles (idle_cycles),
        .tdo_in      (tdo_in),
        .empty       (empty),
        .pop         (pop),
        .tck_cycle   (tck_cycle),
        .tms_out     (tms_out),
        .tdi_out     (tdi_out),
        .done_res    (done_res),
        .read_data   (read_data),
        .tap_now     (tap_now),
        .status      (status),
        .busy_res    (busy_res)
    );

    always #5 clk = ~clk;

    // standard ieee 1149.1 tap transitions
    function automatic tap_state_t tap_advance(tap_state_t s, logic tms);
        case (s)
            TAP_TLR:    return tms ? TAP_TLR    : TAP_RTI;
            TAP_RTI:    return tms ? TAP_SEL_DR : TAP_RTI;
            TAP_SEL_DR: return tms ? TAP_SEL_IR : TAP_CAP_DR;
            TAP_CAP_DR: return tms ? TAP_EX1_DR : TAP_SH_DR;
            TAP_SH_DR:  return tms ? TAP_EX1_DR : TAP_SH_DR;
            TAP_EX1_DR: return tms ? TAP_UPD_DR : TAP_PAU_DR;
            TAP_PAU_DR: return tms ? TAP_EX2_DR : TAP_PAU_DR;
            TAP_EX2_DR: return tms ? TAP_UPD_DR : TAP_SH_DR;
            TAP_UPD_DR: return tms ? TAP_SEL_DR : TAP_RTI;
            TAP_SEL_IR: return tms ? TAP_TLR    : TAP_CAP_IR;
            TAP_CAP_IR: return tms ? TAP_EX1_IR : TAP_SH_IR;
            TAP_SH_IR:  return tms ? TAP_EX1_IR : TAP_SH_IR;
            TAP_EX1_IR: return tms ? TAP_UPD_IR : TAP_PAU_IR;
            TAP_PAU_IR: return tms ? TAP_EX2_IR : TAP_PAU_IR;
            TAP_EX2_IR: return tms ? TAP_UPD_IR : TAP_SH_IR;
            default:    return tms ? TAP_SEL_DR : TAP_RTI;
        endcase
    endfunction

    function automatic seq_model_t seq_reset_state();
        seq_model_t s;
        s = '0;
        s.tap = TAP_TLR;
        s.ph = PH_IDLE;
        return s;
    endfunction

    // one transfer through the sequencer: next state and the result it gives
    function automatic seq_step_t sequencer_step(seq_model_t cur, jtag_item_t it);
        seq_step_t  o;
        seq_model_t s;
        res_t       r;
        logic [6:0] lim;
        logic       tms;
        logic       tdi;
        logic       done;
        logic       ir;
        logic       last;
        tap_state_t target;
        s = cur;
        r = '0;
        tms = 1'b0;
        tdi = 1'b0;
        done = 1'b0;
        r.status = STAT_OK;
        if (it.op <= OP_RUN_IDLE) begin
            // command transfer
            if (s.ph != PH_IDLE) begin
                r.status = STAT_BUSY;
                r.busy = 1'b1;
            end else if ((it.op == OP_SHIFT_IR || it.op == OP_SHIFT_DR) &&
                         (it.cnt == '0 ||
                          it.cnt > ((it.op == OP_SHIFT_IR) ? IR_LEN_MAX : DR_LEN_MAX))) begin
                r.status = STAT_BAD_LEN;
            end else begin
                s.kind = it.op;
                s.cap_bits = '0;
                s.step = '0;
                s.total = (it.op == OP_SHIFT_IR || it.op == OP_SHIFT_DR) ? it.cnt : '0;
                s.out_bits = it.data;
                s.idle_left = '0;
                r.busy = 1'b1;
                if (it.op == OP_TAP_RESET) begin
                    s.ph = PH_RESET;
                end else if (it.op == OP_RUN_IDLE) begin
                    s.idle_left = it.idle;
                    if (s.tap == TAP_RTI && it.idle == '0) begin
                        // already parked in run-test/idle: finishes with no tck cycle
                        s.ph = PH_IDLE;
                        r.done = 1'b1;
                        r.busy = 1'b0;
                    end else begin
                        s.ph = PH_HOME;
                    end
                end else begin
                    s.ph = PH_NAV;
                end
            end
        end else if (s.ph == PH_IDLE) begin
            r.status = STAT_IDLE_TICK;
        end else begin
            // clock tick: one tck cycle
            case (s.ph)
                PH_RESET: begin
                    tms = 1'b1;
                    s.tap = tap_advance(s.tap, 1'b1);
                    s.step = s.step + 7'd1;
                    if (s.step >= RESET_TMS_CYCLES) begin
                        done = 1'b1;
                        s.ph = PH_IDLE;
                    end
                end
                PH_NAV: begin
                    ir = (s.kind == OP_SHIFT_IR);
                    target = ir ? TAP_SH_IR : TAP_SH_DR;
                    case (s.tap)
                        TAP_TLR:                tms = 1'b0;
                        TAP_SEL_DR, TAP_CAP_DR: tms = ir;
                        TAP_SEL_IR, TAP_CAP_IR: tms = ~ir;
                        default:                tms = 1'b1;
                    endcase
                    s.tap = tap_advance(s.tap, tms);
                    if (s.tap == target) begin
                        s.ph = PH_SHIFT;
                        s.step = '0;
                    end
                end
                PH_SHIFT: begin
                    last = ({1'b0, s.step} + 8'd1) >= {1'b0, s.total};
                    tdi = s.out_bits[0];
                    tms = last;
                    if (it.tdo)
                        s.cap_bits[s.step[5:0]] = 1'b1;
                    s.out_bits = s.out_bits >> 1;
                    s.step = s.step + 7'd1;
                    s.tap = tap_advance(s.tap, tms);
                    if (last) begin
                        s.ph = PH_HOME;
                        s.idle_left = '0;
                    end
                end
                default: begin
                    // walk home to run-test/idle, then burn the idle cycles there
                    if (s.tap == TAP_RTI) begin
                        tms = 1'b0;
                        if (s.idle_left != '0)
                            s.idle_left = s.idle_left - 32'd1;
                    end else begin
                        tms = !(s.tap == TAP_TLR || s.tap == TAP_UPD_DR || s.tap == TAP_UPD_IR);
                        s.tap = tap_advance(s.tap, tms);
                    end
                    if (s.tap == TAP_RTI && s.idle_left == '0) begin
                        done = 1'b1;
                        s.ph = PH_IDLE;
                    end
                end
            endcase
            r.tck = 1'b1;
            r.tms = tms;
            r.tdi = tdi;
            r.done = done;
            r.rd = done ? s.cap_bits : '0;
            r.busy = ~done;
        end
        r.tap = s.tap;
        o.st = s;
        o.res = r;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // stimulus planning: a second copy of the predictor tells the planner
    // how many ticks each command still needs
    // ------------------------------------------------------------------

    task automatic queue_item(input logic [2:0] op_v, input logic [63:0] d,
                              input logic [6:0] c, input logic [31:0] idl, input logic t);
        jtag_item_t it;
        seq_step_t  s;
        it.op = op_v;
        it.data = d;
        it.cnt = c;
        it.idle = idl;
        it.tdo = t;
        s = sequencer_step(plan_st, it);
        plan_st = s.st;
        pending_q.push_back(it);
        n_queued++;
    endtask

    function automatic logic [63:0] rand_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // mostly short shifts, now and then the longest or a mid length
    function automatic logic [6:0] rand_len(input logic [6:0] max_len);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return max_len;
        if (pick == 1)
            return 7'd1;
        if (pick < 5)
            return 7'($urandom_range(9, max_len));
        return 7'($urandom_range(1, 8));
    endfunction

    // a clock tick, sometimes on one of the spare op codes; other fields are noise
    task automatic queue_tick();
        logic [2:0] t_op;
        t_op = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(OP_CLOCK_TICK + 1, OP_MAX))
                                           : OP_CLOCK_TICK;
        queue_item(t_op, rand_word(), 7'($urandom_range(0, 127)), $urandom,
                   1'($urandom_range(0, 1)));
    endtask

    // only queued while a command runs, so it is always turned away as busy
    task automatic queue_busy_cmd();
        queue_item(3'($urandom_range(OP_TAP_RESET, OP_RUN_IDLE)), rand_word(),
                   7'($urandom_range(0, 127)), $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic tick_until_idle(input bit noise);
        while (plan_st.ph != PH_IDLE) begin
            if (noise && $urandom_range(0, 19) == 0)
                queue_busy_cmd();
            queue_tick();
        end
    endtask

    task automatic queue_random_command();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            queue_item(OP_TAP_RESET, rand_word(), 7'($urandom_range(0, 127)), $urandom, 1'b0);
        else if (pick < 5)
            queue_item(OP_SHIFT_IR, rand_word(), rand_len(IR_LEN_MAX), $urandom, 1'b0);
        else if (pick < 9)
            queue_item(OP_SHIFT_DR, rand_word(), rand_len(DR_LEN_MAX), $urandom, 1'b0);
        else
            queue_item(OP_RUN_IDLE, rand_word(), 7'($urandom_range(0, 127)),
                       32'($urandom_range(0, 4)), 1'b0);
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of transfers with random gaps, fed from pending_q
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        seq_step_t nxt;
        if (rst_n) begin
            if (push && !full) begin
                // item transfer: predict its result now
                nxt = sequencer_step(pred_st, drv_item);
                pred_st = nxt.st;
                expected_q.push_back(nxt.res);
                n_accepted++;
            end
            if (!push || !full) begin
                if (gap_left > 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    drv_item = pending_q.pop_front();
                    op <= drv_item.op;
                    shift_data <= drv_item.data;
                    bit_count <= drv_item.cnt;
                    idle_cycles <= drv_item.idle;
                    tdo_in <= drv_item.tdo;
                    push <= 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        // now and then a long burst with no gap after it
                        if ($urandom_range(0, 7) == 0) begin
                            burst_left = $urandom_range(30, 80);
                            gap_left = 0;
                        end else begin
                            burst_left = $urandom_range(1, 10);
                            gap_left = $urandom_range(0, 6);
                        end
                    end
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: checks each result transfer against the oldest prediction;
    // pop follows one of four patterns, picked by a counter of monitor cycles
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        res_t want;
        if (rst_n) begin
            if (pop && !empty) begin
                if (expected_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: result transfer with none expected, expected none, actual %h",
                             $time, {tck_cycle, tms_out, tdi_out, done_res, read_data,
                                     tap_now, status, busy_res});
                end else begin
                    want = expected_q.pop_front();
                    check_field("tck_cycle", 64'(want.tck), 64'(tck_cycle));
                    check_field("tms_out", 64'(want.tms), 64'(tms_out));
                    check_field("tdi_out", 64'(want.tdi), 64'(tdi_out));
                    check_field("done_res", 64'(want.done), 64'(done_res));
                    check_field("read_data", want.rd, read_data);
                    check_field("tap_now", 64'(want.tap), 64'(tap_now));
                    check_field("status", 64'(want.status), 64'(status));
                    check_field("busy_res", 64'(want.busy), 64'(busy_res));
                end
            end
            rx_cycle <= rx_cycle + 32'd1;
            case (rx_cycle[8:7])
                2'd0:    pop <= 1'b1;
                2'd1:    pop <= 1'($urandom_range(0, 1));
                2'd2:    pop <= (rx_cycle[2:0] == 3'd0);
                default: pop <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // watchdog: too long with no transfer on either side means a hang
    always @(posedge clk) begin
        if (rst_n) begin
            if ((push && !full) || (pop && !empty))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        pred_st = seq_reset_state();
        plan_st = seq_reset_state();

        // directed: ticks with nothing to do, plain and on a spare op code
        queue_item(OP_CLOCK_TICK, '0, '0, '0, 1'b0);
        queue_item(OP_MAX, '1, 7'h7f, '1, 1'b1);
        // run idle with no extra cycles from test-logic-reset, then again in run-test/idle
        queue_item(OP_RUN_IDLE, '0, '0, '0, 1'b0);
        tick_until_idle(1'b0);
        queue_item(OP_RUN_IDLE, '1, 7'h7f, '0, 1'b0);
        // lengths out of range: zero, one past the limit, the widest count
        queue_item(OP_SHIFT_IR, '1, '0, '0, 1'b0);
        queue_item(OP_SHIFT_IR, '1, IR_LEN_MAX + 7'd1, '0, 1'b0);
        queue_item(OP_SHIFT_DR, '1, '0, '0, 1'b0);
        queue_item(OP_SHIFT_DR, '1, DR_LEN_MAX + 7'd1, '0, 1'b0);
        queue_item(OP_SHIFT_DR, '0, 7'h7f, '1, 1'b0);
        // one-bit instruction shift with a command turned away while it runs
        queue_item(OP_SHIFT_IR, '1, 7'd1, '0, 1'b0);
        queue_item(OP_CLOCK_TICK, '0, '0, '0, 1'b1);
        queue_item(OP_SHIFT_DR, '1, DR_LEN_MAX, '1, 1'b1);
        tick_until_idle(1'b0);
        // tap reset from run-test/idle
        queue_item(OP_TAP_RESET, '0, '0, '0, 1'b0);
        tick_until_idle(1'b0);

        // random: mostly complete commands, some broken ones and some noise
        while (n_queued < ITEM_TARGET) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: begin
                    queue_random_command();
                    tick_until_idle(1'b1);
                end
                13, 14, 15: begin
                    if ($urandom_range(0, 1) == 0)
                        queue_item(OP_SHIFT_IR, rand_word(),
                                   ($urandom_range(0, 3) == 0) ? 7'd0
                                       : 7'($urandom_range(IR_LEN_MAX + 1, 127)),
                                   $urandom, 1'b0);
                    else
                        queue_item(OP_SHIFT_DR, rand_word(),
                                   ($urandom_range(0, 3) == 0) ? 7'd0
                                       : 7'($urandom_range(DR_LEN_MAX + 1, 127)),
                                   $urandom, 1'b0);
                end
                16, 17: begin
                    repeat ($urandom_range(1, 3))
                        queue_tick();
                end
                default: begin
                    // broken sequence: new commands arrive before the running one ends
                    queue_random_command();
                    repeat ($urandom_range(1, 3))
                        if (plan_st.ph != PH_IDLE)
                            queue_tick();
                    repeat ($urandom_range(1, 2))
                        if (plan_st.ph != PH_IDLE)
                            queue_busy_cmd();
                    tick_until_idle(1'b1);
                end
            endcase
        end

        // a run idle too long to finish: the block stays busy from here on
        queue_item(OP_RUN_IDLE, rand_word(), 7'($urandom_range(0, 127)),
                   32'hf000_0000 | $urandom, 1'b0);
        repeat (4)
            queue_tick();
        queue_busy_cmd();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (n_accepted < n_queued || expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
rtl/core/jtag_msq_pkg.sv
rtl/core/jtag_msq_fifo.sv
rtl/core/jtag_msq_front.sv
rtl/core/jtag_msq_back.sv
rtl/core/jtag_master_shift_sequencer_unit.sv
dv/jtag_master_shift_sequencer_unit_tb.sv
